### rtl/core/drm_pkg.sv
package drm_pkg;

    // Longest answer string held in the receive window, in characters
    localparam int MAX_PATTERN = 8;

    localparam int BYTE_W  = 8;
    localparam int WIN_W   = MAX_PATTERN * BYTE_W;
    localparam int LEN_W   = 4;
    localparam int HELD_W  = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int MS_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Input action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_BYTE  = 2'd1;
    localparam logic [1:0] ACT_TICK  = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_WAIT    = 2'd0;
    localparam logic [1:0] STAT_FIRST   = 2'd1;
    localparam logic [1:0] STAT_SECOND  = 2'd2;
    localparam logic [1:0] STAT_TIMEOUT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PATTERN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_LENGTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PATTERN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LENGTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS     = 3'd4;

endpackage

### rtl/core/drm_suffix_match.sv
module drm_suffix_match
    import drm_pkg::*;
(
    input  logic [WIN_W-1:0]  pattern,
    input  logic [LEN_W-1:0]  length,
    input  logic [WIN_W-1:0]  window,
    input  logic [HELD_W-1:0] held,
    output logic              match
);

    logic [LEN_W-1:0] len_clamped;
    logic [LEN_W-1:0] held_ext;

    // Clamp the length to the window size
    assign len_clamped = (length > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : length;
    assign held_ext    = LEN_W'(held);

    // Window byte i (newest first) against pattern character len-1-i
    always_comb
    begin
        logic [LEN_W-1:0] pos;
        logic [IDX_W-1:0] idx;
        match = (len_clamped <= held_ext);
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            pos = len_clamped - LEN_W'(i) - LEN_W'(1);
            idx = pos[IDX_W-1:0];
            if (LEN_W'(i) < len_clamped)
            begin
                if (window[i*BYTE_W +: BYTE_W] != pattern[idx*BYTE_W +: BYTE_W])
                begin
                    match = 1'b0;
                end
            end
        end
    end

endmodule

### rtl/core/dual_response_matcher_timeout.sv
// An accepted input transaction passes the input register and then the result register.
// Throughput: one transaction per cycle unless the output stalls; the suffix compares,
// the tick counter and the outcome update sit in one stage between those two registers.
// Reset: asynchronous, active low; clears configuration, window, byte count,
// elapsed time and outcome (waiting), and empties both pipeline registers.
module dual_response_matcher_timeout
    import drm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            action,
    input  logic [BYTE_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration
    logic [WIN_W-1:0] first_pattern_reg;
    logic [LEN_W-1:0] first_length_reg;
    logic [WIN_W-1:0] second_pattern_reg;
    logic [LEN_W-1:0] second_length_reg;
    logic [MS_W-1:0]  timeout_ms_reg;

    // Input stage
    logic              in_valid_reg;
    logic [1:0]        action_reg;
    logic [BYTE_W-1:0] rx_byte_reg;

    // Wait state
    logic [WIN_W-1:0]  recent_bytes_reg, recent_bytes_next;
    logic [HELD_W-1:0] bytes_held_reg, bytes_held_next;
    logic [MS_W-1:0]   elapsed_ms_reg, elapsed_ms_next;
    logic [1:0]        outcome_reg, outcome_next;

    // Result stage
    logic       out_valid_reg;
    logic [1:0] status_reg;

    logic              advance;
    logic              proc;
    logic [WIN_W-1:0]  window_shift;
    logic [HELD_W-1:0] held_inc;
    logic [MS_W-1:0]   elapsed_inc;
    logic              first_hit;
    logic              second_hit;

    assign advance   = !out_valid_reg || out_ready;
    assign proc      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign cfg_ready = 1'b1;

    // Shift the new byte in and count it
    assign window_shift = {recent_bytes_reg[WIN_W-BYTE_W-1:0], rx_byte_reg};
    assign held_inc     = (bytes_held_reg < HELD_W'(MAX_PATTERN)) ?
                          bytes_held_reg + HELD_W'(1) : bytes_held_reg;
    assign elapsed_inc  = (elapsed_ms_reg != {MS_W{1'b1}}) ?
                          elapsed_ms_reg + MS_W'(1) : elapsed_ms_reg;

    drm_suffix_match u_first_match (
        .pattern (first_pattern_reg),
        .length  (first_length_reg),
        .window  (window_shift),
        .held    (held_inc),
        .match   (first_hit)
    );

    drm_suffix_match u_second_match (
        .pattern (second_pattern_reg),
        .length  (second_length_reg),
        .window  (window_shift),
        .held    (held_inc),
        .match   (second_hit)
    );

    // Next wait state for the item in the input stage
    always_comb
    begin
        recent_bytes_next = recent_bytes_reg;
        bytes_held_next   = bytes_held_reg;
        elapsed_ms_next   = elapsed_ms_reg;
        outcome_next      = outcome_reg;
        unique case (action_reg)
            ACT_START:
            begin
                recent_bytes_next = '0;
                bytes_held_next   = '0;
                elapsed_ms_next   = '0;
                outcome_next      = STAT_WAIT;
            end
            ACT_BYTE:
            begin
                if (outcome_reg == STAT_WAIT)
                begin
                    recent_bytes_next = window_shift;
                    bytes_held_next   = held_inc;
                    if (first_hit)
                    begin
                        outcome_next = STAT_FIRST;
                    end
                    else if (second_hit)
                    begin
                        outcome_next = STAT_SECOND;
                    end
                end
            end
            ACT_TICK:
            begin
                if (outcome_reg == STAT_WAIT)
                begin
                    elapsed_ms_next = elapsed_inc;
                    if (elapsed_inc >= timeout_ms_reg)
                    begin
                        outcome_next = STAT_TIMEOUT;
                    end
                end
            end
            default:
            begin
                outcome_next = outcome_reg;
            end
        endcase
    end

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pattern_reg  <= '0;
            first_length_reg   <= '0;
            second_pattern_reg <= '0;
            second_length_reg  <= '0;
            timeout_ms_reg     <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIRST_PATTERN:  first_pattern_reg  <= cfg_data[WIN_W-1:0];
                CFG_FIRST_LENGTH:   first_length_reg   <= cfg_data[LEN_W-1:0];
                CFG_SECOND_PATTERN: second_pattern_reg <= cfg_data[WIN_W-1:0];
                CFG_SECOND_LENGTH:  second_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_TIMEOUT_MS:     timeout_ms_reg     <= cfg_data[MS_W-1:0];
                default:            timeout_ms_reg     <= timeout_ms_reg;
            endcase
        end
    end

    // Hold control of the input and result stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Capture the input transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg  <= action;
            rx_byte_reg <= rx_byte;
        end
    end

    // Advance the wait state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_bytes_reg <= '0;
            bytes_held_reg   <= '0;
            elapsed_ms_reg   <= '0;
            outcome_reg      <= STAT_WAIT;
        end
        else if (proc)
        begin
            recent_bytes_reg <= recent_bytes_next;
            bytes_held_reg   <= bytes_held_next;
            elapsed_ms_reg   <= elapsed_ms_next;
            outcome_reg      <= outcome_next;
        end
    end

    // Load the result
    always_ff @(posedge clk)
    begin
        if (proc)
        begin
            status_reg <= outcome_next;
        end
    end

`ifndef SYNTHESIS
    a_outcome_final: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && action_reg != ACT_START && outcome_reg != STAT_WAIT)
        |=> outcome_reg == $past(outcome_reg))
        else $error("final outcome changed without a start");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_held_reg <= HELD_W'(MAX_PATTERN))
        else $error("byte count beyond window size");

    a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (proc && action_reg == ACT_START)
        |=> (outcome_reg == STAT_WAIT && bytes_held_reg == '0 && elapsed_ms_reg == '0))
        else $error("start did not clear the wait state");

    a_status_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        proc |=> (out_valid_reg && status_reg == outcome_reg))
        else $error("result does not match the updated outcome");
`endif

endmodule
